// File: rtl/windowed_rms_zcr_similarity_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed RMS / zero-crossing similarity block
// Shared property forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_ZCR_SIMILARITY_DEFINES_SVH
`define WINDOWED_RMS_ZCR_SIMILARITY_DEFINES_SVH

// same-cycle implication
`define WRZS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wrzs: same-cycle check failed");

// next-cycle implication
`define WRZS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wrzs: next-cycle check failed");

`endif

// File: rtl/wrzs_pkg.sv
// ----------------------------------------------------------------------------
// wrzs_pkg
// Types and constants shared by the similarity block.
// ----------------------------------------------------------------------------
`default_nettype none
package wrzs_pkg;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned LenW     = 14;
  localparam int unsigned MinWin   = 64;
  localparam int unsigned MaxWin   = 8192;
  localparam int unsigned ResetWin = 2205;
  localparam int unsigned EnW      = 43;
  localparam int unsigned CrW      = 13;
  localparam int unsigned PosW     = 14;
  localparam int unsigned TotW     = 33;
  localparam int unsigned WinW     = 16;
  localparam int unsigned ScW      = 17;
  localparam int unsigned PctW     = 15;
  localparam int unsigned RmsW     = 23;
  localparam int unsigned ZcW      = 30;
  localparam int unsigned DivW     = 46;
  localparam int unsigned DvsW     = 24;
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic            done;
    logic            eos;
    logic [EnW-1:0]  ref_e;
    logic [EnW-1:0]  gen_e;
    logic [CrW-1:0]  ref_c;
    logic [CrW-1:0]  gen_c;
    logic [LenW-1:0] n;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/wrzs_fifo.sv
// ----------------------------------------------------------------------------
// wrzs_fifo
// Short job queue between the sample front end and the window back end.
// ----------------------------------------------------------------------------
`default_nettype none
module wrzs_fifo import wrzs_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  job_t data_i,
  output logic full_o,
  input  wire  pop_i,
  output job_t data_o,
  output logic empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

// File: rtl/wrzs_front.sv
// ----------------------------------------------------------------------------
// wrzs_front
// Per-sample energy and sign-change accumulation; emits one job per window
// end or end of stream.
// ----------------------------------------------------------------------------
`default_nettype none
module wrzs_front import wrzs_pkg::*; (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      acc_i,
  input  wire signed [SampleW-1:0] ref_i,
  input  wire signed [SampleW-1:0] gen_i,
  input  wire                      eos_i,
  input  wire        [LenW-1:0]    len_i,
  output logic                     push_o,
  output job_t                     job_o
);
  logic [EnW-1:0]            ref_e_q, ref_e_d, gen_e_q, gen_e_d;
  logic [CrW-1:0]            ref_c_q, ref_c_d, gen_c_q, gen_c_d;
  logic signed [SampleW-1:0] ref_p_q, ref_p_d, gen_p_q, gen_p_d;
  logic [PosW-1:0]           pos_q, pos_d, pos_nx;
  logic [LenW-1:0]           n_eff;
  logic [EnW-1:0]            ref_e_nx, gen_e_nx;
  logic [CrW-1:0]            ref_c_nx, gen_c_nx;
  logic                      win_end;

  function automatic logic [EnW-1:0] eadd(logic [EnW-1:0] e, logic signed [SampleW-1:0] s);
    logic signed [2*SampleW-1:0] sq;
    logic [EnW:0]                sum;
    sq  = s * s;
    sum = {1'b0, e} + (EnW + 1)'(unsigned'(sq));
    return sum[EnW] ? {EnW{1'b1}} : sum[EnW-1:0];
  endfunction

  function automatic logic flip(logic signed [SampleW-1:0] a, logic signed [SampleW-1:0] b);
    return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
  endfunction

  always_comb begin
    if (len_i < LenW'(MinWin)) begin
      n_eff = LenW'(MinWin);
    end else if (len_i > LenW'(MaxWin)) begin
      n_eff = LenW'(MaxWin);
    end else begin
      n_eff = len_i;
    end
    ref_e_nx = eadd(ref_e_q, ref_i);
    gen_e_nx = eadd(gen_e_q, gen_i);
    ref_c_nx = ref_c_q + CrW'((pos_q != '0) && flip(ref_i, ref_p_q));
    gen_c_nx = gen_c_q + CrW'((pos_q != '0) && flip(gen_i, gen_p_q));
    pos_nx   = pos_q + 1'b1;
    win_end  = (pos_nx >= PosW'(n_eff));

    push_o      = acc_i && (win_end || eos_i);
    job_o.done  = win_end;
    job_o.eos   = eos_i;
    job_o.ref_e = ref_e_nx;
    job_o.gen_e = gen_e_nx;
    job_o.ref_c = ref_c_nx;
    job_o.gen_c = gen_c_nx;
    job_o.n     = n_eff;

    ref_e_d = ref_e_q;
    gen_e_d = gen_e_q;
    ref_c_d = ref_c_q;
    gen_c_d = gen_c_q;
    ref_p_d = ref_p_q;
    gen_p_d = gen_p_q;
    pos_d   = pos_q;
    if (acc_i) begin
      ref_p_d = ref_i;
      gen_p_d = gen_i;
      if (win_end || eos_i) begin
        ref_e_d = '0;
        gen_e_d = '0;
        ref_c_d = '0;
        gen_c_d = '0;
        pos_d   = '0;
      end else begin
        ref_e_d = ref_e_nx;
        gen_e_d = gen_e_nx;
        ref_c_d = ref_c_nx;
        gen_c_d = gen_c_nx;
        pos_d   = pos_nx;
      end
      if (eos_i) begin
        ref_p_d = '0;
        gen_p_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_e_q <= '0;
      gen_e_q <= '0;
      ref_c_q <= '0;
      gen_c_q <= '0;
      ref_p_q <= '0;
      gen_p_q <= '0;
      pos_q   <= '0;
    end else begin
      ref_e_q <= ref_e_d;
      gen_e_q <= gen_e_d;
      ref_c_q <= ref_c_d;
      gen_c_q <= gen_c_d;
      ref_p_q <= ref_p_d;
      gen_p_q <= gen_p_d;
      pos_q   <= pos_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/wrzs_div.sv
// ----------------------------------------------------------------------------
// wrzs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wrzs_div import wrzs_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  wire  [DivW-1:0] dividend_i,
  input  wire  [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DvsW:0]   rem_sh;
  logic            qbit;

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    qbit   = (rem_sh >= {1'b0, dvs_q});
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(DivW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = qbit ? DvsW'(rem_sh - {1'b0, dvs_q}) : DvsW'(rem_sh);
      quo_d = {quo_q[DivW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end
endmodule
`default_nettype wire

// File: rtl/wrzs_back.sv
// ----------------------------------------------------------------------------
// wrzs_back
// Window scoring sequencer: RMS roots, crossing rates, score, running mean.
// ----------------------------------------------------------------------------
`default_nettype none
module wrzs_back import wrzs_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              empty_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic             out_done_o,
  output logic [ScW-1:0]   out_score_o,
  output logic             out_final_o,
  output logic [PctW-1:0]  out_pct_o,
  output logic [WinW-1:0]  out_count_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_SCORE = 3'd3;
  localparam logic [2:0] S_PCT   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [2:0] P_RREF = 3'd0;
  localparam logic [2:0] P_RGEN = 3'd1;
  localparam logic [2:0] P_ZREF = 3'd2;
  localparam logic [2:0] P_ZGEN = 3'd3;
  localparam logic [2:0] P_PCT  = 3'd5;

  localparam int unsigned SumW    = ScW + 2;
  localparam int unsigned RecipSh = 22;
  localparam logic [19:0] Recip5  = 20'd838861;

  logic [2:0]      st_q, st_d, ph_q, ph_d;
  job_t            job_q, job_d;
  logic [RmsW-1:0] rr_q, rr_d, gr_q, gr_d;
  logic [ZcW-1:0]  rz_q, rz_d, gz_q, gz_d;
  logic [ScW-1:0]  sc_q, sc_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic [WinW-1:0] win_q, win_d;
  logic [DivW-1:0] sx_q, sx_d, sr_q, sr_d, sb_q, sb_d, srb;
  logic            ov_q, ov_d, od_q, od_d, of_q, of_d;
  logic [ScW-1:0]  os_q, os_d;
  logic [PctW-1:0] op_q, op_d;
  logic [WinW-1:0] oc_q, oc_d;

  logic            dstart;
  logic [DivW-1:0] dnum, dquo;
  logic [DvsW-1:0] dden;
  logic            ddone;

  logic [RmsW:0]    ad;
  logic [RmsW+1:0]  a2;
  logic [ZcW:0]     azd;
  logic [ZcW+3:0]   a5;
  logic [ScW-1:0]   amp, tim;
  logic [SumW-1:0]  ssum;
  logic [SumW+19:0] sprod;
  logic [ScW-1:0]   sdiv;
  logic [TotW:0]    tsum;

  wrzs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart),
    .dividend_i (dnum),
    .divisor_i  (dden),
    .done_o     (ddone),
    .quot_o     (dquo)
  );

  assign out_valid_o = ov_q;
  assign out_done_o  = od_q;
  assign out_score_o = os_q;
  assign out_final_o = of_q;
  assign out_pct_o   = op_q;
  assign out_count_o = oc_q;

  always_comb begin
    ad    = (rr_q >= gr_q) ? (RmsW + 1)'(rr_q - gr_q) : (RmsW + 1)'(gr_q - rr_q);
    a2    = {ad, 1'b0};
    amp   = (a2 >= (RmsW + 2)'(65536)) ? '0 : ScW'((RmsW + 2)'(65536) - a2);
    azd   = (rz_q >= gz_q) ? (ZcW + 1)'(rz_q - gz_q) : (ZcW + 1)'(gz_q - rz_q);
    a5    = (ZcW + 4)'(azd) * (ZcW + 4)'(5);
    tim   = (a5 >= (ZcW + 4)'(65536)) ? '0 : ScW'((ZcW + 4)'(65536) - a5);
    ssum  = SumW'(amp) * SumW'(3) + SumW'(tim) * SumW'(2);
    sprod = (SumW + 20)'(ssum) * (SumW + 20)'(Recip5);
    sdiv  = ScW'(sprod >> RecipSh);
    tsum  = {1'b0, tot_q} + (TotW + 1)'(sdiv);
    srb   = sr_q + sb_q;
  end

  always_comb begin
    st_d   = st_q;
    ph_d   = ph_q;
    job_d  = job_q;
    rr_d   = rr_q;
    gr_d   = gr_q;
    rz_d   = rz_q;
    gz_d   = gz_q;
    sc_d   = sc_q;
    pct_d  = pct_q;
    tot_d  = tot_q;
    win_d  = win_q;
    sx_d   = sx_q;
    sr_d   = sr_q;
    sb_d   = sb_q;
    ov_d   = ov_q && !out_ready_i;
    od_d   = od_q;
    os_d   = os_q;
    of_d   = of_q;
    op_d   = op_q;
    oc_d   = oc_q;
    pop_o  = 1'b0;
    dstart = 1'b0;
    dnum   = '0;
    dden   = '0;
    unique case (st_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          sc_d  = '0;
          if (job_i.done) begin
            dstart = 1'b1;
            dnum   = DivW'({job_i.ref_e, 2'b00});
            dden   = DvsW'(job_i.n);
            ph_d   = P_RREF;
            st_d   = S_DIV;
          end else begin
            st_d = S_PCT;
          end
        end
      end
      S_DIV: begin
        if (ddone) begin
          case (ph_q)
            P_RREF, P_RGEN: begin
              sx_d = dquo;
              sr_d = '0;
              sb_d = DivW'(1) << (DivW - 2);
              st_d = S_SQRT;
            end
            P_ZREF: begin
              rz_d   = ZcW'(dquo);
              dstart = 1'b1;
              dnum   = DivW'({job_q.gen_c, 16'h0000});
              dden   = DvsW'(job_q.n);
              ph_d   = P_ZGEN;
            end
            P_ZGEN: begin
              gz_d = ZcW'(dquo);
              st_d = S_SCORE;
            end
            default: begin
              pct_d = (dquo > DivW'({PctW{1'b1}})) ? {PctW{1'b1}} : PctW'(dquo);
              st_d  = S_OUT;
            end
          endcase
        end
      end
      S_SQRT: begin
        if (sb_q == '0) begin
          dstart = 1'b1;
          dden   = DvsW'(job_q.n);
          if (ph_q == P_RREF) begin
            rr_d = RmsW'(sr_q);
            dnum = DivW'({job_q.gen_e, 2'b00});
            ph_d = P_RGEN;
          end else begin
            gr_d = RmsW'(sr_q);
            dnum = DivW'({job_q.ref_c, 16'h0000});
            ph_d = P_ZREF;
          end
          st_d = S_DIV;
        end else begin
          if (sx_q >= srb) begin
            sx_d = sx_q - srb;
            sr_d = (sr_q >> 1) + sb_q;
          end else begin
            sr_d = sr_q >> 1;
          end
          sb_d = sb_q >> 2;
        end
      end
      S_SCORE: begin
        sc_d = sdiv;
        st_d = S_PCT;
        if (win_q != {WinW{1'b1}}) begin
          win_d = win_q + 1'b1;
          tot_d = (tsum > (TotW + 1)'({TotW{1'b1}})) ? {TotW{1'b1}} : tsum[TotW-1:0];
        end
      end
      S_PCT: begin
        pct_d = '0;
        if (job_q.eos && (win_q != '0)) begin
          dstart = 1'b1;
          dnum   = (DivW'(tot_q) << 6) + (DivW'(tot_q) << 5) + (DivW'(tot_q) << 2);
          dden   = DvsW'({win_q, 8'h00});
          ph_d   = P_PCT;
          st_d   = S_DIV;
        end else begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          od_d = job_q.done;
          os_d = job_q.done ? sc_q : '0;
          of_d = job_q.eos;
          op_d = job_q.eos ? pct_q : '0;
          oc_d = win_q;
          if (job_q.eos) begin
            tot_d = '0;
            win_d = '0;
          end
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ph_q  <= P_RREF;
      tot_q <= '0;
      win_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      tot_q <= tot_d;
      win_q <= win_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rr_q  <= rr_d;
    gr_q  <= gr_d;
    rz_q  <= rz_d;
    gz_q  <= gz_d;
    sc_q  <= sc_d;
    pct_q <= pct_d;
    sx_q  <= sx_d;
    sr_q  <= sr_d;
    sb_q  <= sb_d;
    od_q  <= od_d;
    os_q  <= os_d;
    of_q  <= of_d;
    op_q  <= op_d;
    oc_q  <= oc_d;
  end
endmodule
`default_nettype wire

// File: rtl/windowed_rms_zcr_similarity.sv
// Window flow: a pair is taken whenever s_axis_tready is high; a window result
//   follows the closing pair (four 46-step divisions and two 23-step roots).
// End of stream adds one division for the mean, or goes straight out with no window.
// Throughput: one pair per cycle while the two-entry job queue has room;
//   the back end finishes one window job before it takes the next, a stalled output holds it.
// Reset: asynchronous, active low; sums, counts and queue clear, window_length 2205.
// ----------------------------------------------------------------------------
// windowed_rms_zcr_similarity
// RMS and zero-crossing-rate similarity of two sample streams per window.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_rms_zcr_similarity_defines.svh"
module windowed_rms_zcr_similarity import wrzs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [13:0] cfg_data_i,     // window_length
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // ref_sample[15:0], gen_sample[31:16]
  input  wire         s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // window_score[16:0], match_percent[31:17],
                                      // window_count[47:32]
  output logic        m_axis_tlast,   // is_final
  output logic        m_axis_tuser    // window_done
);
  logic [LenW-1:0] len_q;
  logic            acc, push, full, pop, empty;
  job_t            job_in, job_out;
  logic [ScW-1:0]  score;
  logic [PctW-1:0] pct;
  logic [WinW-1:0] cnt;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(ResetWin);
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  wrzs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .ref_i  (s_axis_tdata[15:0]),
    .gen_i  (s_axis_tdata[31:16]),
    .eos_i  (s_axis_tlast),
    .len_i  (len_q),
    .push_o (push),
    .job_o  (job_in)
  );

  wrzs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  wrzs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_done_o  (m_axis_tuser),
    .out_score_o (score),
    .out_final_o (m_axis_tlast),
    .out_pct_o   (pct),
    .out_count_o (cnt)
  );

  assign m_axis_tdata = {cnt, pct, score};

  `WRZS_ASSERT_IMPL(a_has_flag, m_axis_tvalid, m_axis_tuser || m_axis_tlast)
  `WRZS_ASSERT_IMPL(a_score_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[16:0] == 17'd0)
  `WRZS_ASSERT_IMPL(a_pct_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[31:17] == 15'd0)
  `WRZS_ASSERT_NEXT(a_full_stall, full, !s_axis_tready || !full)
endmodule
`default_nettype wire
